// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the RTL. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that an expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ASSERT_ALWAYS failed");

// Check that a consequent holds in the same cycle as its antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ASSERT_IMPLIES failed");

// Check that a consequent holds in the cycle after its antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ASSERT_NEXT failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Types, codes and defaults shared by the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

    // Default sizing
    localparam int STACK_DEPTH_DEF = 128;
    localparam int VALUE_WIDTH_DEF = 32;

    // Multiplier digit: bits of the multiplier retired per cycle
    localparam int MUL_DIGIT = 16;

    // Token opcodes
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_POW  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_ADD  = 3'd4;
    localparam logic [2:0] OP_SUB  = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_UNDER  = 3'd1;
    localparam logic [2:0] ST_OVER   = 3'd2;
    localparam logic [2:0] ST_DIVZ   = 3'd3;
    localparam logic [2:0] ST_NEGEXP = 3'd4;

    // Input beat
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic               last_token;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic signed [31:0] top_value;
        logic [7:0]         depth;
        logic [2:0]         status;
        logic               expr_done;
    } t_out_beat;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MS_AB = 2'd0,   // b * a
        MS_RB = 2'd1,   // running power result * base
        MS_BB = 2'd2    // base * base
    } t_mul_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       push;
        logic       load_ops;
        logic       res_add;
        logic       res_sub;
        logic       mul_start;
        t_mul_sel   mul_sel;
        logic       res_mul;
        logic       div_start;
        logic       res_div;
        logic       pow_init;
        logic       base_sq;
        logic       pop_write;
        logic       set_status;
        logic [2:0] status_code;
        logic       emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] opcode;
        logic       full;
        logic       lt2;
        logic       a_zero;
        logic       a_neg;
        logic       exp_zero;
        logic       exp_lsb;
        logic       mul_done;
        logic       div_done;
        logic       out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hdl/postfix_stack_evaluator_unit.sv =====
// Multiply waits on the digit-serial multiplier and divide on the one-bit-per-cycle divider.
// Power runs square and multiply passes on the shared multiplier.
// One token at a time; the next is taken in the cycle after a result enters the output register,
// which holds it while the consumer stalls.
// Reset clears the stack count and handshake state; stack memory is not cleared.
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit
// Postfix expression evaluator on an operand stack, one result beat per token.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire pse_pkg::t_in_beat  i_in_beat,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output pse_pkg::t_out_beat      o_out_beat
);

    pse_pkg::t_dp_cmd  w_cmd;
    pse_pkg::t_dp_stat w_stat;

    // Sequencer
    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Stack, arithmetic and output register
    pse_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

`default_nettype wire

// ===== hdl/pse_mul.sv =====
// ----------------------------------------------------------------------------
// pse_mul
// Digit-serial wrapping multiplier: low VALUE_WIDTH bits of x * y.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_mul #(
    parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_x,
    input  wire logic [VALUE_WIDTH-1:0] i_y,
    output logic                        o_done,
    output logic [VALUE_WIDTH-1:0]      o_prod
);

    localparam int VW   = VALUE_WIDTH;
    localparam int DIG  = pse_pkg::MUL_DIGIT;
    localparam int NDIG = (VW + DIG - 1) / DIG;
    localparam int YW   = NDIG * DIG;
    localparam int NCW  = $clog2(NDIG + 1);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [NCW-1:0] r_cnt,  n_cnt;
    logic [VW-1:0]  r_acc,  n_acc;
    logic [VW-1:0]  r_x,    n_x;
    logic [YW-1:0]  r_y,    n_y;
    logic [VW-1:0]  w_pp;

    // One partial product per cycle: x times the low digit of y, wrapped
    assign w_pp = r_x * VW'(r_y[DIG-1:0]);

    // Load operands, then retire one digit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = NCW'(NDIG);
            n_acc  = '0;
            n_x    = i_x;
            n_y    = YW'(i_y);
        end else if (r_busy) begin
            n_acc = r_acc + w_pp;
            n_x   = r_x << DIG;
            n_y   = r_y >> DIG;
            n_cnt = r_cnt - NCW'(1);
            if (r_cnt == NCW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ===== hdl/pse_div.sv =====
// ----------------------------------------------------------------------------
// pse_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_div #(
    parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_dividend,
    input  wire logic [VALUE_WIDTH-1:0] i_divisor,
    output logic                        o_done,
    output logic [VALUE_WIDTH-1:0]      o_quo
);

    localparam int VW  = VALUE_WIDTH;
    localparam int CNW = $clog2(VW + 1);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [CNW-1:0] r_cnt,  n_cnt;
    logic [VW-1:0]  r_rem,  n_rem;
    logic [VW-1:0]  r_quo,  n_quo;
    logic [VW-1:0]  r_dvsr, n_dvsr;
    logic [VW:0]    w_shift;
    logic [VW:0]    w_diff;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign w_shift = {r_rem, r_quo[VW-1]};
    assign w_diff  = w_shift - {1'b0, r_dvsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvsr = r_dvsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNW'(VW);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvsr = i_divisor;
        end else if (r_busy) begin
            if (!w_diff[VW]) begin
                n_rem = w_diff[VW-1:0];
                n_quo = {r_quo[VW-2:0], 1'b1};
            end else begin
                n_rem = w_shift[VW-1:0];
                n_quo = {r_quo[VW-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNW'(1);
            if (r_cnt == CNW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dvsr <= n_dvsr;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== hdl/pse_dpath.sv =====
// ----------------------------------------------------------------------------
// pse_dpath
// Operand stack memory, cached top, operand registers, arithmetic and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pse_dpath #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pse_pkg::t_in_beat i_in_beat,
    input  wire pse_pkg::t_dp_cmd  i_cmd,
    output pse_pkg::t_dp_stat      o_stat,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output pse_pkg::t_out_beat     o_out_beat
);

    localparam int VW = VALUE_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Stack memory; entries at and above the count are never read for use
    logic [VW-1:0] r_mem [STACK_DEPTH];
    logic [VW-1:0] r_rd_data;

    logic [CW-1:0]       r_count,     n_count;
    logic [VW-1:0]       r_top,       n_top;
    logic [2:0]          r_op,        n_op;
    logic [VW-1:0]       r_val,       n_val;
    logic                r_last,      n_last;
    logic [VW-1:0]       r_a,         n_a;
    logic [VW-1:0]       r_b,         n_b;
    logic [VW-1:0]       r_res,       n_res;
    logic [VW-1:0]       r_base,      n_base;
    logic [VW-1:0]       r_exp,       n_exp;
    logic [2:0]          r_status,    n_status;
    pse_pkg::t_out_beat  r_out,       n_out;
    logic                r_out_valid, n_out_valid;

    logic [AW-1:0] w_push_addr;
    logic [AW-1:0] w_pop_addr;
    logic [VW-1:0] w_mul_x, w_mul_y, w_mul_prod;
    logic          w_mul_done;
    logic [VW-1:0] w_mag_a, w_mag_b, w_div_quo;
    logic          w_div_neg, w_div_done;

    // Stack addresses: push at count, second operand and result at count - 2
    assign w_push_addr = r_count[AW-1:0];
    assign w_pop_addr  = AW'(r_count - CW'(2));

    // Select multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            pse_pkg::MS_AB: begin
                w_mul_x = r_b;
                w_mul_y = r_a;
            end
            pse_pkg::MS_RB: begin
                w_mul_x = r_res;
                w_mul_y = r_base;
            end
            pse_pkg::MS_BB: begin
                w_mul_x = r_base;
                w_mul_y = r_base;
            end
            default: begin
                w_mul_x = r_b;
                w_mul_y = r_a;
            end
        endcase
    end

    pse_mul #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (w_mul_x),
        .i_y     (w_mul_y),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    // Divide magnitudes, restore the sign afterwards
    assign w_mag_a   = r_a[VW-1] ? (VW'(0) - r_a) : r_a;
    assign w_mag_b   = r_b[VW-1] ? (VW'(0) - r_b) : r_b;
    assign w_div_neg = r_a[VW-1] ^ r_b[VW-1];

    pse_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mag_b),
        .i_divisor  (w_mag_a),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo)
    );

    // Next-state logic driven by controller commands
    always_comb begin
        n_count     = r_count;
        n_top       = r_top;
        n_op        = r_op;
        n_val       = r_val;
        n_last      = r_last;
        n_a         = r_a;
        n_b         = r_b;
        n_res       = r_res;
        n_base      = r_base;
        n_exp       = r_exp;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // Drop the output beat once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.load_in) begin
            n_op     = i_in_beat.opcode;
            n_val    = VW'(i_in_beat.value);
            n_last   = i_in_beat.last_token;
            n_status = pse_pkg::ST_OK;
        end
        if (i_cmd.push) begin
            n_top   = r_val;
            n_count = r_count + CW'(1);
        end
        if (i_cmd.load_ops) begin
            n_a = r_top;
            n_b = r_rd_data;
        end
        if (i_cmd.res_add) begin
            n_res = r_a + r_b;
        end
        if (i_cmd.res_sub) begin
            n_res = r_b - r_a;
        end
        if (i_cmd.res_mul) begin
            n_res = w_mul_prod;
        end
        if (i_cmd.res_div) begin
            n_res = w_div_neg ? (VW'(0) - w_div_quo) : w_div_quo;
        end
        if (i_cmd.pow_init) begin
            n_res  = VW'(1);
            n_base = r_b;
            n_exp  = r_a;
        end
        if (i_cmd.base_sq) begin
            n_base = w_mul_prod;
            n_exp  = r_exp >> 1;
        end
        if (i_cmd.pop_write) begin
            n_top   = r_res;
            n_count = r_count - CW'(1);
        end
        if (i_cmd.set_status) begin
            n_status = i_cmd.status_code;
        end

        // Present the result; a final token empties the stack afterwards
        if (i_cmd.emit) begin
            if (r_count == CW'(0)) begin
                n_out.top_value = '0;
            end else begin
                n_out.top_value = 32'(signed'(r_top));
            end
            n_out.depth     = 8'(r_count);
            n_out.status    = r_status;
            n_out.expr_done = r_last;
            n_out_valid     = 1'b1;
            if (r_last) begin
                n_count = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_op     <= n_op;
        r_val    <= n_val;
        r_last   <= n_last;
        r_a      <= n_a;
        r_b      <= n_b;
        r_res    <= n_res;
        r_base   <= n_base;
        r_exp    <= n_exp;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // Stack memory: one write port, one registered read of the second operand
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[w_push_addr] <= r_val;
        end else if (i_cmd.pop_write) begin
            r_mem[w_pop_addr] <= r_res;
        end
        r_rd_data <= r_mem[w_pop_addr];
    end

    // Status toward the controller
    always_comb begin
        o_stat.opcode   = r_op;
        o_stat.full     = (r_count == CW'(STACK_DEPTH));
        o_stat.lt2      = (r_count < CW'(2));
        o_stat.a_zero   = (r_a == '0);
        o_stat.a_neg    = r_a[VW-1];
        o_stat.exp_zero = (r_exp == '0);
        o_stat.exp_lsb  = r_exp[0];
        o_stat.mul_done = w_mul_done;
        o_stat.div_done = w_div_done;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CW'(STACK_DEPTH))
    `ASSERT_IMPLIES(a_push_room, i_clk, i_rst_n, i_cmd.push, r_count != CW'(STACK_DEPTH))
    `ASSERT_IMPLIES(a_pop_two, i_clk, i_rst_n, i_cmd.pop_write, r_count >= CW'(2))
    `ASSERT_IMPLIES(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !r_out_valid || i_out_ready)
    `ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_cmd.emit && r_last, r_count == '0)

endmodule

`default_nettype wire

// ===== hdl/pse_ctrl.sv =====
// ----------------------------------------------------------------------------
// pse_ctrl
// Token sequencer: decodes each token and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire pse_pkg::t_dp_stat i_stat,
    output pse_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_EXEC   = 10'b0000000100,
        S_MUL    = 10'b0000001000,
        S_DIV    = 10'b0000010000,
        S_POW    = 10'b0000100000,
        S_POW_M  = 10'b0001000000,
        S_POW_S  = 10'b0010000000,
        S_WRITE  = 10'b0100000000,
        S_FINISH = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // Sequence one token
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            // Take a token
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end

            // Check stack room, fetch operands
            S_DECODE: begin
                case (i_stat.opcode)
                    pse_pkg::OP_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = pse_pkg::ST_OVER;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                        n_state = S_FINISH;
                    end
                    pse_pkg::OP_POW, pse_pkg::OP_MUL, pse_pkg::OP_DIV,
                    pse_pkg::OP_ADD, pse_pkg::OP_SUB: begin
                        if (i_stat.lt2) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = pse_pkg::ST_UNDER;
                            n_state           = S_FINISH;
                        end else begin
                            o_cmd.load_ops = 1'b1;
                            n_state        = S_EXEC;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end

            // Start the operation
            S_EXEC: begin
                case (i_stat.opcode)
                    pse_pkg::OP_ADD: begin
                        o_cmd.res_add = 1'b1;
                        n_state       = S_WRITE;
                    end
                    pse_pkg::OP_SUB: begin
                        o_cmd.res_sub = 1'b1;
                        n_state       = S_WRITE;
                    end
                    pse_pkg::OP_MUL: begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_sel   = pse_pkg::MS_AB;
                        n_state         = S_MUL;
                    end
                    pse_pkg::OP_DIV: begin
                        if (i_stat.a_zero) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = pse_pkg::ST_DIVZ;
                            n_state           = S_FINISH;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    pse_pkg::OP_POW: begin
                        if (i_stat.a_neg) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = pse_pkg::ST_NEGEXP;
                            n_state           = S_FINISH;
                        end else begin
                            o_cmd.pow_init = 1'b1;
                            n_state        = S_POW;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end

            // Wait for the product
            S_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.res_mul = 1'b1;
                    n_state       = S_WRITE;
                end
            end

            // Wait for the quotient
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.res_div = 1'b1;
                    n_state       = S_WRITE;
                end
            end

            // Square and multiply, one exponent bit per pass
            S_POW: begin
                if (i_stat.exp_zero) begin
                    n_state = S_WRITE;
                end else if (i_stat.exp_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = pse_pkg::MS_RB;
                    n_state         = S_POW_M;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = pse_pkg::MS_BB;
                    n_state         = S_POW_S;
                end
            end

            S_POW_M: begin
                o_cmd.mul_sel = pse_pkg::MS_BB;
                if (i_stat.mul_done) begin
                    o_cmd.res_mul   = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    n_state         = S_POW_S;
                end
            end

            S_POW_S: begin
                if (i_stat.mul_done) begin
                    o_cmd.base_sq = 1'b1;
                    n_state       = S_POW;
                end
            end

            // Replace the two operands by the result
            S_WRITE: begin
                o_cmd.pop_write = 1'b1;
                n_state         = S_FINISH;
            end

            // Hold until the output register is free
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the postfix stack evaluator. A driver and a monitor
// run off the clock with random idle cycles on both channels; every accepted
// token is run through a behavioral stack model and the predicted beat is
// checked against the next output beat, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_TOKENS = 1750;
    localparam int DRAIN_CYCLES  = 400;
    localparam int MAX_PRINTS    = 100;
    localparam int IDLE_PCT      = 30;
    localparam int SAW           = $clog2(pse_pkg::STACK_DEPTH_DEF);

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic               in_valid  = 1'b0;
    pse_pkg::t_in_beat  in_beat   = '0;
    logic               out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    pse_pkg::t_out_beat o_out_beat;

    // Tokens waiting for the driver, and beats predicted but not yet seen
    pse_pkg::t_in_beat  pending_tokens[$];
    pse_pkg::t_out_beat expected_results[$];

    int unsigned queued_count  = 0;
    int unsigned sent_count    = 0;
    int unsigned mismatch_count = 0;

    // Model of the operand stack
    logic [31:0] eval_stack [pse_pkg::STACK_DEPTH_DEF];
    int unsigned eval_depth = 0;

    postfix_stack_evaluator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (o_out_beat)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stack model
    // ------------------------------------------------------------------

    // Square and multiply, every product wrapped to 32 bits; 0^0 is 1
    function automatic logic [31:0] wrap_power(logic [31:0] base, logic [31:0] expo);
        logic [31:0] acc;
        acc = 32'd1;
        while (expo != 32'd0) begin
            if (expo[0])
                acc = acc * base;
            base = base * base;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    // Signed division truncating toward zero; most negative / -1 wraps
    function automatic logic [31:0] trunc_div(logic [31:0] num, logic [31:0] den);
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        logic [31:0] quo;
        mag_n = num[31] ? -num : num;
        mag_d = den[31] ? -den : den;
        quo   = mag_n / mag_d;
        if (num[31] != den[31])
            quo = -quo;
        return quo;
    endfunction

    // Apply one token to the model stack and return the beat it produces
    function automatic pse_pkg::t_out_beat evaluate_token(pse_pkg::t_in_beat tok);
        pse_pkg::t_out_beat res;
        logic [31:0]        opa;
        logic [31:0]        opb;
        logic [31:0]        folded;
        logic [2:0]         status;
        logic               commit;
        status = pse_pkg::ST_OK;
        folded = '0;
        case (tok.opcode)
            pse_pkg::OP_PUSH: begin
                if (eval_depth >= pse_pkg::STACK_DEPTH_DEF) begin
                    status = pse_pkg::ST_OVER;
                end else begin
                    eval_stack[SAW'(eval_depth)] = tok.value;
                    eval_depth++;
                end
            end
            pse_pkg::OP_POW, pse_pkg::OP_MUL, pse_pkg::OP_DIV,
            pse_pkg::OP_ADD, pse_pkg::OP_SUB: begin
                if (eval_depth < 2) begin
                    status = pse_pkg::ST_UNDER;
                end else begin
                    opa    = eval_stack[SAW'(eval_depth - 1)];
                    opb    = eval_stack[SAW'(eval_depth - 2)];
                    commit = 1'b1;
                    case (tok.opcode)
                        pse_pkg::OP_POW: begin
                            if (opa[31]) begin
                                status = pse_pkg::ST_NEGEXP;
                                commit = 1'b0;
                            end else begin
                                folded = wrap_power(opb, opa);
                            end
                        end
                        pse_pkg::OP_MUL: folded = opb * opa;
                        pse_pkg::OP_DIV: begin
                            if (opa == 32'd0) begin
                                status = pse_pkg::ST_DIVZ;
                                commit = 1'b0;
                            end else begin
                                folded = trunc_div(opb, opa);
                            end
                        end
                        pse_pkg::OP_ADD: folded = opa + opb;
                        default: folded = opb - opa;
                    endcase
                    // Pop two, push the result
                    if (commit) begin
                        eval_depth--;
                        eval_stack[SAW'(eval_depth - 1)] = folded;
                    end
                end
            end
            default: ;
        endcase
        res.top_value = (eval_depth > 0) ? eval_stack[SAW'(eval_depth - 1)] : 32'sd0;
        res.depth     = eval_depth[7:0];
        res.status    = status;
        res.expr_done = tok.last_token;
        // Drop the whole stack once the expression ends
        if (tok.last_token)
            eval_depth = 0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // No idling on either side for a stretch of the run
    function automatic logic calm_stretch();
        return (sent_count >= 700) && (sent_count < 1000);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued tokens, hold each until accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_results.push_back(evaluate_token(in_beat));
                sent_count++;
            end
            if (!(in_valid && !o_in_ready)) begin
                if (pending_tokens.size() != 0 &&
                    (calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_beat  <= pending_tokens.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        pse_pkg::t_out_beat want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat, top_value", o_out_beat.top_value, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_beat.top_value !== want.top_value)
                        report_mismatch("top_value", o_out_beat.top_value, want.top_value);
                    if (o_out_beat.depth !== want.depth)
                        report_mismatch("depth", o_out_beat.depth, want.depth);
                    if (o_out_beat.status !== want.status)
                        report_mismatch("status", o_out_beat.status, want.status);
                    if (o_out_beat.expr_done !== want.expr_done)
                        report_mismatch("expr_done", o_out_beat.expr_done, want.expr_done);
                end
            end
            out_ready <= calm_stretch() || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_token(logic [2:0] op, logic [31:0] val, logic last);
        pse_pkg::t_in_beat tok;
        tok.opcode     = op;
        tok.value      = val;
        tok.last_token = last;
        pending_tokens.push_back(tok);
        queued_count++;
    endtask

    // Operands lean toward small numbers, zero and the extremes
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5, 6: return $urandom;
            default: return $urandom_range(0, 40) - 20;
        endcase
    endfunction

    function automatic logic [2:0] rand_operator();
        return 3'($urandom_range(pse_pkg::OP_POW, pse_pkg::OP_SUB));
    endfunction

    initial begin
        int unsigned leaves;
        int unsigned depth_guess;
        int unsigned n_ops;
        logic        drop_last;
        logic        is_last;

        // Directed: extremes, every operator and the underflow, divide-by-zero and negative-exponent paths
        queue_token(pse_pkg::OP_ADD,  32'd0,         1'b0);   // underflow on empty stack
        queue_token(pse_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b0);
        queue_token(pse_pkg::OP_SUB,  32'd0,         1'b0);   // underflow with one value
        queue_token(pse_pkg::OP_PUSH, 32'd1,         1'b0);
        queue_token(pse_pkg::OP_ADD,  32'd0,         1'b0);   // wraps to most negative
        queue_token(pse_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0);
        queue_token(pse_pkg::OP_DIV,  32'd0,         1'b0);   // most negative / -1
        queue_token(pse_pkg::OP_PUSH, 32'd0,         1'b0);
        queue_token(pse_pkg::OP_DIV,  32'd0,         1'b0);   // divide by zero, operands stay
        queue_token(pse_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0);
        queue_token(pse_pkg::OP_POW,  32'd0,         1'b0);   // negative exponent
        queue_token(pse_pkg::OP_SUB,  32'd0,         1'b0);
        queue_token(pse_pkg::OP_MUL,  32'd0,         1'b0);
        queue_token(pse_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b0);
        queue_token(pse_pkg::OP_MUL,  32'd0,         1'b0);
        queue_token(3'd6,             32'h1234_5678, 1'b0);   // undefined opcodes
        queue_token(3'd7,             32'hFFFF_FFFF, 1'b0);
        queue_token(pse_pkg::OP_PUSH, 32'd0,         1'b0);
        queue_token(pse_pkg::OP_PUSH, 32'd0,         1'b0);
        queue_token(pse_pkg::OP_POW,  32'd0,         1'b0);   // zero to the zero
        queue_token(pse_pkg::OP_PUSH, 32'd3,         1'b0);
        queue_token(pse_pkg::OP_PUSH, 32'd21,        1'b0);
        queue_token(pse_pkg::OP_POW,  32'd0,         1'b0);   // wrapping power
        queue_token(pse_pkg::OP_PUSH, 32'hFFFF_FFF9, 1'b0);
        queue_token(pse_pkg::OP_DIV,  32'd0,         1'b1);   // truncation, ends expression

        // Random: mostly well-formed expressions, some noise, a few stack fills
        while (queued_count < 25 + RANDOM_TOKENS) begin
            case ($urandom_range(0, 59))
                0: begin
                    // Fill the stack to the top or past it, then fold a few and finish
                    repeat (pse_pkg::STACK_DEPTH_DEF + $urandom_range(0, 3))
                        queue_token(pse_pkg::OP_PUSH, rand_operand(), 1'b0);
                    n_ops = $urandom_range(1, 6);
                    for (int k = 0; k < n_ops; k++)
                        queue_token(rand_operator(), $urandom, (k == n_ops - 1));
                end
                1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    // Noise: any opcode, random end marker
                    repeat ($urandom_range(1, 4))
                        queue_token(3'($urandom_range(0, 7)), $urandom,
                                    ($urandom_range(0, 3) == 0));
                end
                default: begin
                    // Well-formed expression; now and then its end marker is dropped
                    leaves      = $urandom_range(1, 10);
                    depth_guess = 0;
                    drop_last   = ($urandom_range(0, 7) == 0);
                    while (leaves > 0 || depth_guess > 1) begin
                        if (depth_guess < 2 || (leaves > 0 && $urandom_range(0, 1) == 1)) begin
                            leaves--;
                            depth_guess++;
                            is_last = (leaves == 0) && (depth_guess == 1);
                            queue_token(pse_pkg::OP_PUSH, rand_operand(),
                                        is_last && !drop_last);
                        end else begin
                            depth_guess--;
                            is_last = (leaves == 0) && (depth_guess == 1);
                            queue_token(rand_operator(), $urandom, is_last && !drop_last);
                        end
                    end
                end
            endcase
        end

        // Reset, then let the driver run dry
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_tokens.size() != 0 || in_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0)
            report_mismatch("missing beats", expected_results.size(), 0);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/pse_pkg.sv
hdl/pse_mul.sv
hdl/pse_div.sv
hdl/pse_dpath.sv
hdl/pse_ctrl.sv
hdl/postfix_stack_evaluator_unit.sv
sim/testbench.sv
